@@ sv/epac_pkg.sv @@
// epac_pkg: shared constants for the edge pixel area coverage block
// no dependencies; used by the channel interfaces, the divider and the top level
package epac_pkg;

  localparam int DEF_COORD_WIDTH     = 24;
  localparam int DEF_COORD_FRAC_BITS = 12;
  localparam int COV_WIDTH           = 18;

  // quotient bits of the slope divider (Q.28 fraction in 0..1) and crossing divider
  localparam int T_QBITS   = 29;
  localparam int X_QBITS   = 17;
  // restoring steps per divider stage
  localparam int DIV_STEPS = 4;

  localparam int QONE  = 65536;
  localparam int QHALF = 32768;

endpackage

@@ sv/epac_if.sv @@
// epac_edge_if / epac_cov_if: valid/ready channels of the coverage block
// depends on epac_pkg for default widths
interface epac_edge_if import epac_pkg::*; #(parameter int CW = DEF_COORD_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;

  modport source(output valid, output start_x, output start_y, output end_x, output end_y,
                 input ready);
  modport sink(input valid, input start_x, input start_y, input end_x, input end_y,
               output ready);
endinterface

interface epac_cov_if import epac_pkg::*; #(parameter int COV_W = COV_WIDTH);
  logic                    valid;
  logic                    ready;
  logic signed [COV_W-1:0] coverage;

  modport source(output valid, output coverage, input ready);
  modport sink(input valid, input coverage, output ready);
endinterface

@@ sv/edge_pixel_area_coverage.sv @@
// edge_pixel_area_coverage: signed pixel coverage of one line edge, fixed-point pipeline
// depends on epac_pkg, epac_if (channels) and epac_div (slope and crossing dividers)
//
//   channel   | dir | payload                               | beat
//   in_edge   | in  | start_x, start_y, end_x, end_y        | valid & ready
//   out_cov   | out | coverage (signed Q2.16)               | valid & ready
//
// one beat in per cycle unless the output stalls, one result per beat;
// the slope and crossing dividers set the pipeline depth.
// all stages advance together; a stalled output holds the whole pipeline.
// synchronous active-low reset clears only the stage valid bits.
module edge_pixel_area_coverage import epac_pkg::*; #(
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  epac_edge_if.sink  in_edge,
  epac_cov_if.source out_cov
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = COORD_FRAC_BITS;
  localparam int L    = 16 - F;
  localparam int WW   = F + 2;
  localparam int DXW  = CW + 1;
  localparam int NTW  = CW + 2;
  localparam int UTW  = CW + T_QBITS;
  localparam int PTW  = CW + 31;
  localparam int PRW  = CW + T_QBITS;
  localparam int KT   = 28 - L;
  localparam int KR   = 29 - L;
  localparam int HDW  = CW + L;
  localparam int YMW  = CW + L + 3;
  localparam int NW   = YMW + 1;
  localparam int DW2  = HDW + 1;
  localparam int UW2  = NW + X_QBITS;
  localparam int SW   = 17;
  localparam int PW   = 34;
  localparam int A2W  = 36;
  localparam int MW   = A2W + WW;
  localparam int KC   = 17 + F;
  localparam int NS1  = (T_QBITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NS2  = (X_QBITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int LAT  = 12 + NS1 + NS2;

  localparam logic signed [CW-1:0] HALF  = CW'(1) <<< (F - 1);
  localparam logic signed [CW-1:0] NHALF = -HALF;

  typedef struct packed {
    logic                  zero;
    logic signed [WW-1:0]  w;
    logic signed [CW-1:0]  y0;
    logic signed [DXW-1:0] dy;
    logic [CW-1:0]         ady;
  } side1_t;

  typedef struct packed {
    logic                 zero;
    logic signed [WW-1:0] w;
    logic [SW-1:0]        sr;
    logic [SW-1:0]        sl;
    logic                 neg_t;
    logic                 nz_t;
    logic                 ovf_t;
    logic                 neg_b;
    logic                 nz_b;
    logic                 ovf_b;
  } side2_t;

  function automatic logic [SW-1:0] clamp_unit(input logic signed [NW:0] v);
    logic [SW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > QONE) begin
      res = SW'(QONE);
    end else begin
      res = v[SW-1:0];
    end
    return res;
  endfunction

  // crossing quotient to clamped side value
  function automatic logic [SW-1:0] side_of(input logic [X_QBITS-1:0] q, input logic neg,
                                            input logic nz, input logic ovf);
    logic [SW-1:0] res;
    if (!nz) begin
      res = SW'(QHALF);
    end else if (ovf || q >= X_QBITS'(QHALF)) begin
      res = neg ? '0 : SW'(QONE);
    end else if (neg) begin
      res = SW'(QHALF) - SW'(q);
    end else begin
      res = SW'(QHALF) + SW'(q);
    end
    return res;
  endfunction

  logic           en;
  logic [LAT-1:0] v_r;

  assign en            = out_cov.ready || !v_r[LAT-1];
  assign in_edge.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_edge.valid};
    end
  end

  // stage a: clamp x to the window, take the edge deltas
  logic signed [CW-1:0]  wx0_nxt, wx1_nxt;
  logic signed [CW-1:0]  a_y0_r;
  logic signed [WW-1:0]  a_w_r;
  logic signed [DXW-1:0] a_dx_r, a_dy_r;
  logic signed [NTW-1:0] a_nt_r;

  always_comb begin
    if (in_edge.start_x < NHALF) begin
      wx0_nxt = NHALF;
    end else if (in_edge.start_x > HALF) begin
      wx0_nxt = HALF;
    end else begin
      wx0_nxt = in_edge.start_x;
    end
    if (in_edge.end_x < NHALF) begin
      wx1_nxt = NHALF;
    end else if (in_edge.end_x > HALF) begin
      wx1_nxt = HALF;
    end else begin
      wx1_nxt = in_edge.end_x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_y0_r <= in_edge.start_y;
      a_w_r  <= WW'(wx1_nxt) - WW'(wx0_nxt);
      a_dx_r <= DXW'(in_edge.end_x) - DXW'(in_edge.start_x);
      a_dy_r <= DXW'(in_edge.end_y) - DXW'(in_edge.start_y);
      a_nt_r <= NTW'(wx0_nxt) + NTW'(wx1_nxt) - (NTW'(in_edge.start_x) <<< 1);
    end
  end

  // stage b: magnitudes and rounding bias for the slope dividers
  logic [CW-1:0]      adx_nxt, ady_nxt;
  logic [CW:0]        mag_nt_nxt;
  logic [F:0]         mag_w_nxt;
  logic [UTW-1:0]     unt_nxt, unr_nxt;
  logic [CW-1:0]      b_hi_t_r, b_hi_r_r, b_den_r;
  logic [T_QBITS-1:0] b_lo_t_r, b_lo_r_r;
  side1_t             b_side_r;

  always_comb begin
    adx_nxt    = a_dx_r[DXW-1] ? CW'(-a_dx_r) : CW'(a_dx_r);
    ady_nxt    = a_dy_r[DXW-1] ? CW'(-a_dy_r) : CW'(a_dy_r);
    mag_nt_nxt = a_nt_r[NTW-1] ? (CW+1)'(-a_nt_r) : (CW+1)'(a_nt_r);
    mag_w_nxt  = a_w_r[WW-1] ? (F+1)'(-a_w_r) : (F+1)'(a_w_r);
    unt_nxt    = (UTW'(mag_nt_nxt) << (T_QBITS - 2)) + UTW'(adx_nxt >> 1);
    unr_nxt    = (UTW'(mag_w_nxt) << (T_QBITS - 1)) + UTW'(adx_nxt >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_hi_t_r      <= unt_nxt[UTW-1:T_QBITS];
      b_lo_t_r      <= unt_nxt[T_QBITS-1:0];
      b_hi_r_r      <= unr_nxt[UTW-1:T_QBITS];
      b_lo_r_r      <= unr_nxt[T_QBITS-1:0];
      b_den_r       <= adx_nxt;
      b_side_r.zero <= (a_w_r == '0);
      b_side_r.w    <= a_w_r;
      b_side_r.y0   <= a_y0_r;
      b_side_r.dy   <= a_dy_r;
      b_side_r.ady  <= ady_nxt;
    end
  end

  // slope dividers: t (window middle along the edge) and r (width over dx)
  logic [T_QBITS-1:0] t_q, r_q;
  side1_t             sd1_r [NS1];

  epac_div #(.DW(CW), .QW(T_QBITS), .STEPS(DIV_STEPS)) u_div_t (
    .clk(clk), .en(en), .rem_i(b_hi_t_r), .lo_i(b_lo_t_r), .den_i(b_den_r), .quo_o(t_q)
  );

  epac_div #(.DW(CW), .QW(T_QBITS), .STEPS(DIV_STEPS)) u_div_r (
    .clk(clk), .en(en), .rem_i(b_hi_r_r), .lo_i(b_lo_r_r), .den_i(b_den_r), .quo_o(r_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r[0] <= b_side_r;
      for (int i = 1; i < NS1; i++) begin
        sd1_r[i] <= sd1_r[i-1];
      end
    end
  end

  // stage c: t*dy and |dy|*r
  logic signed [PTW-1:0] c_pt_r;
  logic [PRW-1:0]        c_pr_r;
  logic signed [CW-1:0]  c_y0_r;
  logic signed [WW-1:0]  c_w_r;
  logic                  c_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_pt_r   <= PTW'($signed({1'b0, t_q})) * PTW'(sd1_r[NS1-1].dy);
      c_pr_r   <= PRW'(sd1_r[NS1-1].ady) * PRW'(r_q);
      c_y0_r   <= sd1_r[NS1-1].y0;
      c_w_r    <= sd1_r[NS1-1].w;
      c_zero_r <= sd1_r[NS1-1].zero;
    end
  end

  // stage d: ym and hd with round half away from zero
  logic signed [PTW-1:0] pt_bias, pt_shift;
  logic signed [YMW-1:0] d_ym_r;
  logic [HDW-1:0]        d_hd_r;
  logic signed [WW-1:0]  d_w_r;
  logic                  d_zero_r;

  always_comb begin
    pt_bias  = c_pt_r + (PTW'(1) <<< (KT - 1)) - PTW'($signed({1'b0, c_pt_r[PTW-1]}));
    pt_shift = pt_bias >>> KT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ym_r   <= (YMW'(c_y0_r) <<< L) + YMW'(pt_shift);
      d_hd_r   <= HDW'((c_pr_r + (PRW'(1) << (KR - 1))) >> KR);
      d_w_r    <= c_w_r;
      d_zero_r <= c_zero_r;
    end
  end

  // stage e1: crossing numerators, right and left sides
  logic signed [NW:0]   sr_sum, sl_sum;
  logic signed [NW-1:0] e1_nt_r, e1_nb_r;
  logic [SW-1:0]        e1_sr_r, e1_sl_r;
  logic [HDW-1:0]       e1_hd_r;
  logic signed [WW-1:0] e1_w_r;
  logic                 e1_zero_r;

  always_comb begin
    sr_sum = (NW+1)'(d_ym_r) + (NW+1)'($signed({1'b0, d_hd_r})) + (NW+1)'(QHALF);
    sl_sum = (NW+1)'(d_ym_r) - (NW+1)'($signed({1'b0, d_hd_r})) + (NW+1)'(QHALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_nt_r   <= NW'(QHALF) - NW'(d_ym_r);
      e1_nb_r   <= -NW'(QHALF) - NW'(d_ym_r);
      e1_sr_r   <= clamp_unit(sr_sum);
      e1_sl_r   <= clamp_unit(sl_sum);
      e1_hd_r   <= d_hd_r;
      e1_w_r    <= d_w_r;
      e1_zero_r <= d_zero_r;
    end
  end

  // stage e2: |num| << 16 plus rounding bias (divisor is 2*hd, half of it is hd)
  logic [NW-1:0]        mt_nxt, mb_nxt;
  logic [UW2-1:0]       e2_un_t_r, e2_un_b_r;
  logic                 e2_neg_t_r, e2_neg_b_r, e2_nz_t_r, e2_nz_b_r;
  logic [HDW-1:0]       e2_hd_r;
  logic [SW-1:0]        e2_sr_r, e2_sl_r;
  logic signed [WW-1:0] e2_w_r;
  logic                 e2_zero_r;

  always_comb begin
    mt_nxt = e1_nt_r[NW-1] ? ~e1_nt_r : e1_nt_r;
    mb_nxt = e1_nb_r[NW-1] ? ~e1_nb_r : e1_nb_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_un_t_r  <= (UW2'(mt_nxt) << 16) + UW2'(e1_hd_r) + (UW2'(e1_nt_r[NW-1]) << 16);
      e2_un_b_r  <= (UW2'(mb_nxt) << 16) + UW2'(e1_hd_r) + (UW2'(e1_nb_r[NW-1]) << 16);
      e2_neg_t_r <= e1_nt_r[NW-1];
      e2_neg_b_r <= e1_nb_r[NW-1];
      e2_nz_t_r  <= (e1_nt_r != '0);
      e2_nz_b_r  <= (e1_nb_r != '0);
      e2_hd_r    <= e1_hd_r;
      e2_sr_r    <= e1_sr_r;
      e2_sl_r    <= e1_sl_r;
      e2_w_r     <= e1_w_r;
      e2_zero_r  <= e1_zero_r;
    end
  end

  // stage e3: overflow check against the divisor, covers the zero-rise case too
  logic [DW2-1:0]     ud2_nxt;
  logic [NW-1:0]      hi_t_nxt, hi_b_nxt;
  logic               ovf_t_nxt, ovf_b_nxt;
  logic [DW2-1:0]     e3_rem_t_r, e3_rem_b_r, e3_den_r;
  logic [X_QBITS-1:0] e3_lo_t_r, e3_lo_b_r;
  side2_t             e3_side_r;

  always_comb begin
    ud2_nxt   = {e2_hd_r, 1'b0};
    hi_t_nxt  = e2_un_t_r[UW2-1:X_QBITS];
    hi_b_nxt  = e2_un_b_r[UW2-1:X_QBITS];
    ovf_t_nxt = (hi_t_nxt >= NW'(ud2_nxt));
    ovf_b_nxt = (hi_b_nxt >= NW'(ud2_nxt));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e3_rem_t_r      <= ovf_t_nxt ? '0 : hi_t_nxt[DW2-1:0];
      e3_rem_b_r      <= ovf_b_nxt ? '0 : hi_b_nxt[DW2-1:0];
      e3_lo_t_r       <= e2_un_t_r[X_QBITS-1:0];
      e3_lo_b_r       <= e2_un_b_r[X_QBITS-1:0];
      e3_den_r        <= ud2_nxt;
      e3_side_r.zero  <= e2_zero_r;
      e3_side_r.w     <= e2_w_r;
      e3_side_r.sr    <= e2_sr_r;
      e3_side_r.sl    <= e2_sl_r;
      e3_side_r.neg_t <= e2_neg_t_r;
      e3_side_r.nz_t  <= e2_nz_t_r;
      e3_side_r.ovf_t <= ovf_t_nxt;
      e3_side_r.neg_b <= e2_neg_b_r;
      e3_side_r.nz_b  <= e2_nz_b_r;
      e3_side_r.ovf_b <= ovf_b_nxt;
    end
  end

  // crossing dividers: top and bottom
  logic [X_QBITS-1:0] tx_q, bx_q;
  side2_t             sd2_r [NS2];

  epac_div #(.DW(DW2), .QW(X_QBITS), .STEPS(DIV_STEPS)) u_div_tx (
    .clk(clk), .en(en), .rem_i(e3_rem_t_r), .lo_i(e3_lo_t_r), .den_i(e3_den_r), .quo_o(tx_q)
  );

  epac_div #(.DW(DW2), .QW(X_QBITS), .STEPS(DIV_STEPS)) u_div_bx (
    .clk(clk), .en(en), .rem_i(e3_rem_b_r), .lo_i(e3_lo_b_r), .den_i(e3_den_r), .quo_o(bx_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r[0] <= e3_side_r;
      for (int i = 1; i < NS2; i++) begin
        sd2_r[i] <= sd2_r[i-1];
      end
    end
  end

  // stage f: top and bottom sides
  logic [SW-1:0]        f_st_r, f_sb_r, f_sr_r, f_sl_r;
  logic signed [WW-1:0] f_w_r;
  logic                 f_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f_st_r   <= side_of(tx_q, sd2_r[NS2-1].neg_t, sd2_r[NS2-1].nz_t, sd2_r[NS2-1].ovf_t);
      f_sb_r   <= side_of(bx_q, sd2_r[NS2-1].neg_b, sd2_r[NS2-1].nz_b, sd2_r[NS2-1].ovf_b);
      f_sr_r   <= sd2_r[NS2-1].sr;
      f_sl_r   <= sd2_r[NS2-1].sl;
      f_w_r    <= sd2_r[NS2-1].w;
      f_zero_r <= sd2_r[NS2-1].zero;
    end
  end

  // stage g: st*(1-sl) and sr*(1-sb)
  logic [PW-1:0]        g_p1_r, g_p2_r;
  logic signed [WW-1:0] g_w_r;
  logic                 g_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_p1_r   <= PW'(f_st_r) * PW'(SW'(QONE) - f_sl_r);
      g_p2_r   <= PW'(f_sr_r) * PW'(SW'(QONE) - f_sb_r);
      g_w_r    <= f_w_r;
      g_zero_r <= f_zero_r;
    end
  end

  // stage h: twice the area, Q.32
  logic signed [A2W-1:0] h_a2_r;
  logic signed [WW-1:0]  h_w_r;
  logic                  h_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_a2_r   <= A2W'(g_p1_r) - A2W'(g_p2_r) - (A2W'(1) << 32);
      h_w_r    <= g_w_r;
      h_zero_r <= g_zero_r;
    end
  end

  // stage i: scale by the signed width
  logic signed [MW-1:0] i_m_r;
  logic                 i_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      i_m_r    <= MW'(h_a2_r) * MW'(h_w_r);
      i_zero_r <= h_zero_r;
    end
  end

  // output stage: round, clamp to -1..1
  logic signed [MW-1:0]        m_bias, m_shift;
  logic signed [COV_WIDTH-1:0] cov_nxt;
  logic signed [COV_WIDTH-1:0] o_cov_r;

  always_comb begin
    m_bias  = i_m_r + (MW'(1) <<< (KC - 1)) - MW'($signed({1'b0, i_m_r[MW-1]}));
    m_shift = m_bias >>> KC;
    if (i_zero_r) begin
      cov_nxt = '0;
    end else if (m_shift > QONE) begin
      cov_nxt = COV_WIDTH'(QONE);
    end else if (m_shift < -QONE) begin
      cov_nxt = -COV_WIDTH'(QONE);
    end else begin
      cov_nxt = m_shift[COV_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_cov_r <= cov_nxt;
    end
  end

  assign out_cov.valid    = v_r[LAT-1];
  assign out_cov.coverage = o_cov_r;

endmodule

@@ sv/epac_div.sv @@
// epac_div: pipelined restoring divider, STEPS quotient bits per stage
// depends on epac_pkg; caller supplies a start remainder below the divisor
module epac_div import epac_pkg::*; #(
  parameter int DW    = DEF_COORD_WIDTH,
  parameter int QW    = T_QBITS,
  parameter int STEPS = DIV_STEPS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int NS = (QW + STEPS - 1) / STEPS;

  logic [DW-1:0] rem_r [NS-1];
  logic [DW-1:0] den_r [NS-1];
  logic [QW-1:0] acc_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] rem_in, den_in, rem_c;
    logic [QW-1:0] acc_in, acc_c;
    logic [DW:0]   trial;
    logic          qbit;

    if (s == 0) begin : g_first
      assign rem_in = rem_i;
      assign acc_in = lo_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign acc_in = acc_r[s-1];
      assign den_in = den_r[s-1];
    end

    // numerator bits shift out the top of acc, quotient bits shift in below
    always_comb begin
      rem_c = rem_in;
      acc_c = acc_in;
      trial = '0;
      qbit  = 1'b0;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < QW) begin
          trial = {rem_c, acc_c[QW-1]};
          if (trial >= {1'b0, den_in}) begin
            rem_c = DW'(trial - {1'b0, den_in});
            qbit  = 1'b1;
          end else begin
            rem_c = trial[DW-1:0];
            qbit  = 1'b0;
          end
          acc_c = {acc_c[QW-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[s] <= acc_c;
      end
    end

    if (s < NS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_c;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = acc_r[NS-1];

endmodule
